[hw/rtl/tmq_pkg.sv]
// shared constants, codes and the item type of the typed message queue engine
// no dependencies; imported by tmq_front, tmq_back and the top level
package tmq_pkg;

  localparam int unsigned QUEUE_COUNT  = 8;
  localparam int unsigned QUEUE_BYTES  = 4096;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_REFS     = 64;

  // only queues reachable through the 3-bit id fields
  localparam int unsigned NQ          = (QUEUE_COUNT < 8) ? QUEUE_COUNT : 8;
  localparam int unsigned OFF_W       = $clog2(QUEUE_BYTES);
  localparam int unsigned USED_W      = OFF_W + 1;
  localparam int unsigned SUM_W       = USED_W + 1;
  localparam int unsigned REFS_W      = $clog2(MAX_REFS + 1);
  localparam int unsigned STORE_DEPTH = QUEUE_COUNT * QUEUE_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned SPAN_W      = SIZE_W + 1;
  localparam int unsigned FIFO_DEPTH  = 2;

  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_SEND    = 3'd3;
  localparam logic [2:0] OP_RECV    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOQ     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOSPACE = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;
  localparam logic [2:0] ST_BADSEQ  = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        op_known;
    logic [31:0] queue_key;
    logic [2:0]  queue_id;
    logic [31:0] msg_type;
    logic [11:0] byte_count;
    logic [7:0]  data_byte;
    logic [7:0]  proc_mask;
  } tmq_item_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] q,
                                                   input logic [USED_W-1:0] off);
    return ADDR_W'(q) * ADDR_W'(QUEUE_BYTES) + ADDR_W'(off[OFF_W-1:0]);
  endfunction

endpackage

[hw/rtl/tmq_ram.sv]
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module tmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tmq_front.sv]
// front end: accepts words, tags known opcodes and queues them for the back end
// depends on tmq_pkg
module tmq_front import tmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] queue_key_i,
  input  logic [2:0]  queue_id_i,
  input  logic [31:0] msg_type_i,
  input  logic [11:0] byte_count_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  proc_mask_i,
  output logic        item_valid_o,
  output tmq_item_t   item_o,
  input  logic        item_pop_i
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  tmq_item_t         fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push;
  tmq_item_t         item_new;

  assign in_ready_o   = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fifo_q[rd_ptr_q];

  always_comb begin
    item_new.opcode     = opcode_i;
    item_new.op_known   = (opcode_i <= OP_READ);
    item_new.queue_key  = queue_key_i;
    item_new.queue_id   = queue_id_i;
    item_new.msg_type   = msg_type_i;
    item_new.byte_count = byte_count_i;
    item_new.data_byte  = data_byte_i;
    item_new.proc_mask  = proc_mask_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

[hw/rtl/tmq_back.sv]
// back end: queue table, send and read sequencing, header scan and compaction
// depends on tmq_pkg and tmq_ram
module tmq_back import tmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  tmq_item_t   item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  queue_index_o,
  output logic [7:0]  new_mask_o,
  output logic [7:0]  data_out_o,
  output logic        data_last_o,
  output logic [11:0] msg_size_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHDR  = 4'd1;
  localparam logic [3:0] S_SDATA = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_HDR   = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_RDB   = 4'd6;
  localparam logic [3:0] S_MVRD  = 4'd7;
  localparam logic [3:0] S_MVWR  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic              in_use_q [NQ];
  logic              in_use_d [NQ];
  logic [31:0]       key_q [NQ];
  logic [31:0]       key_d [NQ];
  logic [REFS_W-1:0] refs_q [NQ];
  logic [REFS_W-1:0] refs_d [NQ];
  logic [USED_W-1:0] used_q [NQ];
  logic [USED_W-1:0] used_d [NQ];

  logic              send_active_q, send_active_d;
  logic [2:0]        send_queue_q, send_queue_d;
  logic [USED_W-1:0] send_left_q, send_left_d;
  logic [USED_W-1:0] send_ptr_q, send_ptr_d;
  logic              read_active_q, read_active_d;
  logic [2:0]        read_queue_q, read_queue_d;
  logic [USED_W-1:0] read_ptr_q, read_ptr_d;
  logic [USED_W-1:0] read_left_q, read_left_d;
  logic [USED_W-1:0] read_off_q, read_off_d;
  logic [SIZE_W-1:0] read_size_q, read_size_d;

  tmq_item_t         cur_q, cur_d;
  logic [2:0]        k_q, k_d;
  logic [USED_W-1:0] off_q, off_d;
  logic [47:0]       hdr_q, hdr_d;
  logic [2:0]        mv_q_q, mv_q_d;
  logic [USED_W-1:0] mv_src_q, mv_src_d;
  logic [USED_W-1:0] mv_dst_q, mv_dst_d;
  logic [USED_W-1:0] mv_cnt_q, mv_cnt_d;
  logic [SPAN_W-1:0] mv_len_q, mv_len_d;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q, status_d;
  logic [2:0]        qidx_q, qidx_d;
  logic [7:0]        nmask_q, nmask_d;
  logic [7:0]        dout_q, dout_d;
  logic              last_q, last_d;
  logic [11:0]       msize_q, msize_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  logic              key_hit, free_found, out_free, out_set;
  logic [2:0]        hit_idx, free_idx;
  logic [SUM_W-1:0]  need;
  logic [SPAN_W-1:0] span_end, rl;
  logic [SPAN_W-1:0] mv_src_w;
  logic [SIZE_W-1:0] hsize;

  tmq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // lowest active queue with the key, lowest free slot
  always_comb begin
    key_hit    = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NQ - 1; i >= 0; i--) begin
      if (in_use_q[i] && key_q[i] == item_i.queue_key) begin
        key_hit = 1'b1;
        hit_idx = 3'(i);
      end
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = 3'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign hsize    = hdr_q[47:32];

  always_comb begin
    state_d       = state_q;
    in_use_d      = in_use_q;
    key_d         = key_q;
    refs_d        = refs_q;
    used_d        = used_q;
    send_active_d = send_active_q;
    send_queue_d  = send_queue_q;
    send_left_d   = send_left_q;
    send_ptr_d    = send_ptr_q;
    read_active_d = read_active_q;
    read_queue_d  = read_queue_q;
    read_ptr_d    = read_ptr_q;
    read_left_d   = read_left_q;
    read_off_d    = read_off_q;
    read_size_d   = read_size_q;
    cur_d         = cur_q;
    k_d           = k_q;
    off_d         = off_q;
    hdr_d         = hdr_q;
    mv_q_d        = mv_q_q;
    mv_src_d      = mv_src_q;
    mv_dst_d      = mv_dst_q;
    mv_cnt_d      = mv_cnt_q;
    mv_len_d      = mv_len_q;
    status_d      = status_q;
    qidx_d        = qidx_q;
    nmask_d       = nmask_q;
    dout_d        = dout_q;
    last_d        = last_q;
    msize_d       = msize_q;
    out_set       = 1'b0;
    item_pop_o    = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    need          = '0;
    span_end      = '0;
    rl            = '0;
    mv_src_w      = '0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          status_d   = ST_OK;
          qidx_d     = '0;
          nmask_d    = '0;
          dout_d     = '0;
          last_d     = 1'b0;
          msize_d    = '0;
          case (item_i.opcode)
            OP_GET: begin
              out_set = 1'b1;
              if (key_hit) begin
                qidx_d  = hit_idx;
                nmask_d = item_i.proc_mask | (8'd1 << hit_idx);
                if (!item_i.proc_mask[hit_idx] && refs_q[hit_idx] < REFS_W'(MAX_REFS)) begin
                  refs_d[hit_idx] = refs_q[hit_idx] + 1'b1;
                end
              end else if (free_found) begin
                qidx_d             = free_idx;
                in_use_d[free_idx] = 1'b1;
                key_d[free_idx]    = item_i.queue_key;
                refs_d[free_idx]   = REFS_W'(1);
                used_d[free_idx]   = '0;
                nmask_d            = item_i.proc_mask | (8'd1 << free_idx);
              end else begin
                status_d = ST_FULL;
                nmask_d  = item_i.proc_mask;
              end
            end
            OP_ADD, OP_RELEASE: begin
              out_set = 1'b1;
              for (int i = 0; i < NQ; i++) begin
                if (item_i.proc_mask[i] && in_use_q[i]) begin
                  if (item_i.opcode == OP_ADD) begin
                    if (refs_q[i] < REFS_W'(MAX_REFS)) begin
                      refs_d[i] = refs_q[i] + 1'b1;
                    end
                  end else if (refs_q[i] <= REFS_W'(1)) begin
                    // last reference gone: free the queue and drop its transfers
                    in_use_d[i] = 1'b0;
                    key_d[i]    = '0;
                    refs_d[i]   = '0;
                    used_d[i]   = '0;
                    if (send_active_q && send_queue_q == 3'(i)) begin
                      send_active_d = 1'b0;
                    end
                    if (read_active_q && read_queue_q == 3'(i)) begin
                      read_active_d = 1'b0;
                    end
                  end else begin
                    refs_d[i] = refs_q[i] - 1'b1;
                  end
                end
              end
            end
            OP_SEND: begin
              if (!send_active_q) begin
                qidx_d = item_i.queue_id;
                need   = SUM_W'(used_q[item_i.queue_id]) + SUM_W'(item_i.byte_count)
                       + SUM_W'(HEADER_BYTES);
                if (32'(item_i.queue_id) >= NQ || !in_use_q[item_i.queue_id]) begin
                  status_d = ST_NOQ;
                  out_set  = 1'b1;
                end else if (read_active_q && read_queue_q == item_i.queue_id) begin
                  status_d = ST_BADSEQ;
                  out_set  = 1'b1;
                end else if (need > SUM_W'(QUEUE_BYTES)) begin
                  status_d = ST_NOSPACE;
                  out_set  = 1'b1;
                end else begin
                  send_queue_d = item_i.queue_id;
                  off_d        = used_q[item_i.queue_id];
                  send_ptr_d   = used_q[item_i.queue_id] + USED_W'(HEADER_BYTES);
                  send_left_d  = USED_W'(item_i.byte_count);
                  k_d          = '0;
                  state_d      = S_SHDR;
                end
              end else begin
                qidx_d     = send_queue_q;
                we         = 1'b1;
                waddr      = store_addr(send_queue_q, send_ptr_q);
                wdata      = item_i.data_byte;
                send_ptr_d = send_ptr_q + 1'b1;
                send_left_d = send_left_q - 1'b1;
                if (send_left_q == USED_W'(1)) begin
                  used_d[send_queue_q] = send_ptr_q + 1'b1;
                  send_active_d        = 1'b0;
                  last_d               = 1'b1;
                end
                out_set = 1'b1;
              end
            end
            OP_RECV: begin
              qidx_d = item_i.queue_id;
              if (32'(item_i.queue_id) >= NQ || !in_use_q[item_i.queue_id]) begin
                status_d = ST_NOQ;
                out_set  = 1'b1;
              end else if (read_active_q ||
                           (send_active_q && send_queue_q == item_i.queue_id)) begin
                status_d = ST_BADSEQ;
                out_set  = 1'b1;
              end else begin
                off_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_READ: begin
              if (!read_active_q) begin
                status_d = ST_BADSEQ;
                out_set  = 1'b1;
              end else begin
                qidx_d  = read_queue_q;
                raddr   = store_addr(read_queue_q, read_ptr_q);
                state_d = S_RDB;
              end
            end
            default: begin
              status_d = ST_BADSEQ;
              out_set  = 1'b1;
            end
          endcase
        end
      end

      // header: type bytes, then the length, little endian
      S_SHDR: begin
        we    = 1'b1;
        waddr = store_addr(send_queue_q, off_q + USED_W'(k_q));
        case (k_q)
          3'd0: wdata = cur_q.msg_type[7:0];
          3'd1: wdata = cur_q.msg_type[15:8];
          3'd2: wdata = cur_q.msg_type[23:16];
          3'd3: wdata = cur_q.msg_type[31:24];
          3'd4: wdata = cur_q.byte_count[7:0];
          default: wdata = {4'd0, cur_q.byte_count[11:8]};
        endcase
        k_d = k_q + 1'b1;
        if (k_q == 3'd5) begin
          if (cur_q.byte_count == '0) begin
            used_d[send_queue_q] = send_ptr_q;
            last_d               = 1'b1;
            out_set              = 1'b1;
            state_d              = S_IDLE;
          end else begin
            state_d = S_SDATA;
          end
        end
      end

      S_SDATA: begin
        we          = 1'b1;
        waddr       = store_addr(send_queue_q, send_ptr_q);
        wdata       = cur_q.data_byte;
        send_ptr_d  = send_ptr_q + 1'b1;
        send_left_d = send_left_q - 1'b1;
        if (send_left_q == USED_W'(1)) begin
          used_d[send_queue_q] = send_ptr_q + 1'b1;
          last_d               = 1'b1;
        end else begin
          send_active_d = 1'b1;
        end
        out_set = 1'b1;
        state_d = S_IDLE;
      end

      S_SCAN: begin
        if (SUM_W'(off_q) + SUM_W'(HEADER_BYTES) > SUM_W'(used_q[cur_q.queue_id])) begin
          status_d = ST_NOMATCH;
          out_set  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          raddr   = store_addr(cur_q.queue_id, off_q);
          k_d     = 3'd1;
          state_d = S_HDR;
        end
      end

      // one header byte per cycle; the registered read data trails its address
      S_HDR: begin
        hdr_d = {rdata, hdr_q[47:8]};
        if (k_q == 3'd6) begin
          state_d = S_EVAL;
        end else begin
          raddr = store_addr(cur_q.queue_id, off_q + USED_W'(k_q));
          k_d   = k_q + 1'b1;
        end
      end

      S_EVAL: begin
        span_end = SPAN_W'(off_q) + SPAN_W'(HEADER_BYTES) + SPAN_W'(hsize);
        if (span_end > SPAN_W'(used_q[cur_q.queue_id])) begin
          status_d = ST_NOMATCH;
          out_set  = 1'b1;
          state_d  = S_IDLE;
        end else if (hdr_q[31:0] == cur_q.msg_type) begin
          msize_d = hsize[11:0];
          rl = (SPAN_W'(cur_q.byte_count) < SPAN_W'(hsize)) ? SPAN_W'(cur_q.byte_count)
                                                           : SPAN_W'(hsize);
          if (rl == '0) begin
            last_d   = 1'b1;
            mv_q_d   = cur_q.queue_id;
            mv_dst_d = off_q;
            mv_src_d = span_end[USED_W-1:0];
            mv_cnt_d = used_q[cur_q.queue_id] - span_end[USED_W-1:0];
            mv_len_d = SPAN_W'(HEADER_BYTES) + SPAN_W'(hsize);
            state_d  = S_MVRD;
          end else begin
            read_active_d = 1'b1;
            read_queue_d  = cur_q.queue_id;
            read_off_d    = off_q;
            read_ptr_d    = off_q + USED_W'(HEADER_BYTES);
            read_left_d   = rl[USED_W-1:0];
            read_size_d   = hsize;
            out_set       = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          off_d   = span_end[USED_W-1:0];
          state_d = S_SCAN;
        end
      end

      S_RDB: begin
        dout_d      = rdata;
        read_ptr_d  = read_ptr_q + 1'b1;
        read_left_d = read_left_q - 1'b1;
        if (read_left_q == USED_W'(1)) begin
          read_active_d = 1'b0;
          last_d        = 1'b1;
          mv_src_w      = SPAN_W'(read_off_q) + SPAN_W'(HEADER_BYTES) + SPAN_W'(read_size_q);
          mv_q_d        = read_queue_q;
          mv_dst_d      = read_off_q;
          mv_src_d      = mv_src_w[USED_W-1:0];
          mv_cnt_d      = used_q[read_queue_q] - mv_src_w[USED_W-1:0];
          mv_len_d      = SPAN_W'(HEADER_BYTES) + SPAN_W'(read_size_q);
          state_d       = S_MVRD;
        end else begin
          out_set = 1'b1;
          state_d = S_IDLE;
        end
      end

      // compaction: move the tail down over the removed message
      S_MVRD: begin
        if (mv_cnt_q == '0) begin
          used_d[mv_q_q] = used_q[mv_q_q] - mv_len_q[USED_W-1:0];
          out_set        = 1'b1;
          state_d        = S_IDLE;
        end else begin
          raddr   = store_addr(mv_q_q, mv_src_q);
          state_d = S_MVWR;
        end
      end

      S_MVWR: begin
        we       = 1'b1;
        waddr    = store_addr(mv_q_q, mv_dst_q);
        wdata    = rdata;
        mv_src_d = mv_src_q + 1'b1;
        mv_dst_d = mv_dst_q + 1'b1;
        mv_cnt_d = mv_cnt_q - 1'b1;
        state_d  = S_MVRD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    if (out_set) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      send_active_q <= 1'b0;
      send_queue_q  <= '0;
      send_left_q   <= '0;
      send_ptr_q    <= '0;
      read_active_q <= 1'b0;
      read_queue_q  <= '0;
      read_ptr_q    <= '0;
      read_left_q   <= '0;
      read_off_q    <= '0;
      read_size_q   <= '0;
      for (int i = 0; i < NQ; i++) begin
        in_use_q[i] <= 1'b0;
        key_q[i]    <= '0;
        refs_q[i]   <= '0;
        used_q[i]   <= '0;
      end
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      send_active_q <= send_active_d;
      send_queue_q  <= send_queue_d;
      send_left_q   <= send_left_d;
      send_ptr_q    <= send_ptr_d;
      read_active_q <= read_active_d;
      read_queue_q  <= read_queue_d;
      read_ptr_q    <= read_ptr_d;
      read_left_q   <= read_left_d;
      read_off_q    <= read_off_d;
      read_size_q   <= read_size_d;
      in_use_q      <= in_use_d;
      key_q         <= key_d;
      refs_q        <= refs_d;
      used_q        <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    k_q      <= k_d;
    off_q    <= off_d;
    hdr_q    <= hdr_d;
    mv_q_q   <= mv_q_d;
    mv_src_q <= mv_src_d;
    mv_dst_q <= mv_dst_d;
    mv_cnt_q <= mv_cnt_d;
    mv_len_q <= mv_len_d;
    status_q <= status_d;
    qidx_q   <= qidx_d;
    nmask_q  <= nmask_d;
    dout_q   <= dout_d;
    last_q   <= last_d;
    msize_q  <= msize_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign queue_index_o = qidx_q;
  assign new_mask_o    = nmask_q;
  assign data_out_o    = dout_q;
  assign data_last_o   = last_q;
  assign msg_size_o    = msize_q;

endmodule

[hw/rtl/typed_message_queue_engine_core.sv]
// typed message queue engine, top level: front end queue plus back end sequencer
// depends on tmq_pkg, tmq_front, tmq_back (and tmq_ram below it)
//
// usage
// - input channel in_valid_i/in_ready_o carries one op word (get, add_mask,
//   release_mask, send_byte, receive_select, read_byte); output channel
//   out_valid_o/out_ready_i returns exactly one result word per op word
// - a 2-entry front queue takes words while the back end is busy, so the
//   sender only stalls when that queue is full
// - back end handles one word at a time; the result is registered in the cycle after
//   the word leaves the front queue for get, mask ops, send data bytes and decode errors
// - read_byte: the address goes out on decode; S_RDB takes the registered store data
// - send start: six header writes then the first data byte (header only if empty)
// - receive_select: six byte reads per message header walked, then a check in S_EVAL
// - the last read_byte, or a zero length receive, compacts the queue store, each
//   byte moved through a store read in S_MVRD then a store write in S_MVWR
// - send data bytes stream at one word per cycle while the result register is free
// - reset clears the queue table and transfer state; the store needs no
//   clearing pass, unwritten bytes are never read
// - a stalled receiver holds the result register; the back end waits with it
//   and the front queue keeps filling
module typed_message_queue_engine_core import tmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] queue_key_i,
  input  logic [2:0]  queue_id_i,
  input  logic [31:0] msg_type_i,
  input  logic [11:0] byte_count_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  proc_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  queue_index_o,
  output logic [7:0]  new_mask_o,
  output logic [7:0]  data_out_o,
  output logic        data_last_o,
  output logic [11:0] msg_size_o
);

  // front to back hand-off
  logic      item_valid;
  logic      item_pop;
  tmq_item_t item;

  tmq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .queue_key_i  (queue_key_i),
    .queue_id_i   (queue_id_i),
    .msg_type_i   (msg_type_i),
    .byte_count_i (byte_count_i),
    .data_byte_i  (data_byte_i),
    .proc_mask_i  (proc_mask_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  tmq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .queue_index_o (queue_index_o),
    .new_mask_o    (new_mask_o),
    .data_out_o    (data_out_o),
    .data_last_o   (data_last_o),
    .msg_size_o    (msg_size_o)
  );

`ifndef SYNTH
  // a last flag only ever comes with a successful op
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_last_o) |-> (status_o == ST_OK))
    else $error("last flag with error status");

  // a message size only comes from a receive select, never with a mask
  a_size_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && msg_size_o != 12'd0) |-> (status_o == ST_OK && new_mask_o == 8'd0))
    else $error("message size on a non-receive result");

  // the back end never pops an empty front queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("pop from empty front queue");

  // a full table result names no queue
  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (queue_index_o == 3'd0))
    else $error("table full result carries a queue index");
`endif

endmodule
